[rtl/wfa_pkg.sv]
package wfa_pkg;

  localparam int CHANNELS_DEF   = 4;
  localparam int MAX_WINDOW_DEF = 64;

  localparam int CH_IN_W    = 2;
  localparam int FORCE_W    = 16;
  localparam int WLEN_W     = 7;
  localparam int GAIN_W     = 24;
  localparam int POS_W      = 32;
  localparam int NUM_BASE   = 4;
  localparam int FRAC_SHIFT = 20;
  localparam int CFG_IDX_W  = 3;

  localparam logic [WLEN_W-1:0]        WLEN_RESET = WLEN_W'(16);
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 3'd0,
    CFG_GAIN          = 3'd1,
    CFG_BASE_POS_0    = 3'd2,
    CFG_BASE_POS_1    = 3'd3,
    CFG_BASE_POS_2    = 3'd4,
    CFG_BASE_POS_3    = 3'd5
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_FIN    = 5'b10000
  } state_e;

endpackage

[rtl/wfa_ram.sv]
module wfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/windowed_force_admittance.sv]
// Windowed force admittance controller.
// Input channel: in_valid_i / in_stall_o with channel_i and force_sample_i (Q4.12).
// Output channel: out_valid_o / out_stall_i with out_channel_o, average_force_o and
// target_position_o. A beat moves on a rising edge with valid high and stall low.
// Each sample replaces the oldest entry of its channel's sliding window, and one
// result beat follows: the truncated window average and base_pos + gain * average,
// saturated to 32 bits. Window samples live in a single-port-write RAM; a per-channel
// wrap flag makes never-written slots read as zero, so no clearing pass is needed.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i. Writing only while
// idle is up to the user; the block itself does not enforce it. Writing window_length
// empties every window at once. Each item steps through accept, a window update, the
// bit-serial multiplier and the radix-2 dividers, then a finishing add and saturate.
// Once the result is loaded into the output register the block returns to idle and
// can take the next beat, even while the result still waits in the output register.
// If the receiver stalls and the output register is full, the finished item holds
// in its last step and the input stays stalled until the waiting beat is taken.
// Reset empties all windows, loads register defaults and drops any pending result.
module windowed_force_admittance
  import wfa_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [POS_W-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CH_IN_W-1:0]        channel_i,
  input  logic signed [FORCE_W-1:0] force_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [CH_IN_W-1:0]        out_channel_o,
  output logic signed [FORCE_W-1:0] average_force_o,
  output logic signed [POS_W-1:0]   target_position_o
);

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH   = CHANNELS * MAX_WINDOW;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SL_W    = (SLOT_W + 1 > WLEN_W) ? SLOT_W + 1 : WLEN_W;
  localparam int SUM_W   = FORCE_W + $clog2(MAX_WINDOW) + 1;
  localparam int PROD_W  = GAIN_W + SUM_W;
  localparam int DIV_N   = PROD_W - FRAC_SHIFT;
  localparam int CNT_W   = $clog2(DIV_N);
  localparam int T_W     = ((DIV_N + 1 > POS_W) ? DIV_N + 1 : POS_W) + 1;

  // Configuration registers
  logic [WLEN_W-1:0]        window_length_q;
  logic signed [GAIN_W-1:0] gain_q;
  logic signed [POS_W-1:0]  base_pos_q [NUM_BASE];
  logic                     wlen_wr;

  always_comb begin
    wlen_wr = 1'b0;
    if (cfg_we_i && cfg_idx_i == CFG_WINDOW_LENGTH) begin
      wlen_wr = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WLEN_RESET;
      gain_q          <= GAIN_RESET;
      for (int i = 0; i < NUM_BASE; i++) begin
        base_pos_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        CFG_WINDOW_LENGTH: begin
          window_length_q <= cfg_data_i[WLEN_W-1:0];
        end
        CFG_GAIN: begin
          gain_q <= cfg_data_i[GAIN_W-1:0];
        end
        CFG_BASE_POS_0, CFG_BASE_POS_1, CFG_BASE_POS_2, CFG_BASE_POS_3: begin
          base_pos_q[2'(cfg_idx_i - CFG_BASE_POS_0)] <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  logic [WLEN_W-1:0] len_w;

  always_comb begin
    if (window_length_q == '0) begin
      len_w = WLEN_W'(1);
    end else if ({{(32-WLEN_W){1'b0}}, window_length_q} > MAX_WINDOW) begin
      len_w = WLEN_W'(MAX_WINDOW);
    end else begin
      len_w = window_length_q;
    end
  end

  // Control
  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             in_acc;
  logic             out_free;
  logic             mul_last;
  logic             div_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign mul_last   = (cnt_q == CNT_W'(SUM_W - 1));
  assign div_last   = (cnt_q == CNT_W'(DIV_N - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (mul_last) begin
          state_d = ST_DIV;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Channel lookup and window addressing on the accepted beat
  logic [2:0]        ch_map;
  logic [CH_W-1:0]   ch_in_idx;
  logic [SLOT_W-1:0] slot_q [CHANNELS];
  logic [AW-1:0]     raddr;

  always_comb begin
    ch_map = {1'b0, channel_i};
    for (int i = 0; i < 3; i++) begin
      if ({29'b0, ch_map} >= CHANNELS) begin
        ch_map = ch_map - 3'(CHANNELS);
      end
    end
  end

  assign ch_in_idx = CH_W'(ch_map);
  assign raddr     = AW'(ch_in_idx * MAX_WINDOW) + AW'(slot_q[ch_in_idx]);

  // Item registers
  logic [CH_IN_W-1:0]        ch_in_q;
  logic [CH_W-1:0]           ch_q;
  logic [1:0]                base_idx_q;
  logic signed [FORCE_W-1:0] force_q;
  logic [SLOT_W-1:0]         slot_cur_q;
  logic [AW-1:0]             addr_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_in_q    <= channel_i;
      ch_q       <= ch_in_idx;
      base_idx_q <= ch_map[1:0];
      force_q    <= force_sample_i;
      slot_cur_q <= slot_q[ch_in_idx];
      addr_q     <= raddr;
    end
  end

  logic signed [FORCE_W-1:0] ram_rdata;
  logic                      st_update;

  assign st_update = (state_q == ST_UPDATE);

  wfa_ram #(
    .WIDTH (FORCE_W),
    .DEPTH (DEPTH)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (st_update),
    .waddr_i (addr_q),
    .wdata_i (force_q),
    .re_i    (in_acc),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // Window update
  logic signed [SUM_W-1:0]   sum_q [CHANNELS];
  logic [CHANNELS-1:0]       wrapped_q;
  logic signed [FORCE_W-1:0] old_w;
  logic signed [SUM_W-1:0]   sum_new;
  logic [SUM_W-1:0]          sum_mag;
  logic [SL_W-1:0]           slot_inc;
  logic                      slot_wrap;
  logic [SLOT_W-1:0]         slot_next;

  assign old_w     = wrapped_q[ch_q] ? ram_rdata : '0;
  assign sum_new   = sum_q[ch_q] - SUM_W'(old_w) + SUM_W'(force_q);
  assign sum_mag   = sum_new[SUM_W-1] ? (~sum_new + 1'b1) : sum_new;
  assign slot_inc  = SL_W'(slot_cur_q) + 1'b1;
  assign slot_wrap = (slot_inc >= SL_W'(len_w));
  assign slot_next = slot_wrap ? '0 : SLOT_W'(slot_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrapped_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i]  <= '0;
        slot_q[i] <= '0;
      end
    end else if (wlen_wr) begin
      wrapped_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i]  <= '0;
        slot_q[i] <= '0;
      end
    end else if (st_update) begin
      sum_q[ch_q]  <= sum_new;
      slot_q[ch_q] <= slot_next;
      if (slot_wrap) begin
        wrapped_q[ch_q] <= 1'b1;
      end
    end
  end

  // Bit-serial multiply of |gain| by |sum|, then radix-2 division of both |sum| and
  // the product bits above FRAC_SHIFT by the window length
  logic [GAIN_W-1:0]  g_mag;
  logic [GAIN_W-1:0]  g_q;
  logic               sum_neg_q;
  logic [PROD_W-1:0]  prod_q;
  logic [PROD_W-1:0]  prod_d;
  logic [GAIN_W:0]    prod_add;
  logic [DIV_N-1:0]   div_a_q, div_b_q;
  logic [WLEN_W-1:0]  rem_a_q, rem_b_q;
  logic [WLEN_W:0]    shl_a, shl_b;
  logic               ge_a, ge_b;
  logic [WLEN_W:0]    rem_a_d, rem_b_d;

  assign g_mag    = gain_q[GAIN_W-1] ? (~gain_q + 1'b1) : gain_q;
  assign prod_add = {1'b0, prod_q[PROD_W-1:SUM_W]} + (prod_q[0] ? {1'b0, g_q} : '0);
  assign prod_d   = {prod_add, prod_q[SUM_W-1:1]};

  assign shl_a   = {rem_a_q, div_a_q[DIV_N-1]};
  assign shl_b   = {rem_b_q, div_b_q[DIV_N-1]};
  assign ge_a    = (shl_a >= {1'b0, len_w});
  assign ge_b    = (shl_b >= {1'b0, len_w});
  assign rem_a_d = ge_a ? (shl_a - {1'b0, len_w}) : shl_a;
  assign rem_b_d = ge_b ? (shl_b - {1'b0, len_w}) : shl_b;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_UPDATE: begin
        g_q       <= g_mag;
        sum_neg_q <= sum_new[SUM_W-1];
        prod_q    <= PROD_W'(sum_mag);
        div_a_q   <= DIV_N'(sum_mag);
        rem_a_q   <= '0;
      end
      ST_MUL: begin
        prod_q <= prod_d;
        if (mul_last) begin
          div_b_q <= prod_d[PROD_W-1:FRAC_SHIFT];
          rem_b_q <= '0;
        end
      end
      ST_DIV: begin
        div_a_q <= {div_a_q[DIV_N-2:0], ge_a};
        div_b_q <= {div_b_q[DIV_N-2:0], ge_b};
        rem_a_q <= rem_a_d[WLEN_W-1:0];
        rem_b_q <= rem_b_d[WLEN_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Sign, offset and saturate
  logic                      p_neg;
  logic signed [T_W-1:0]     base_ext;
  logic signed [T_W-1:0]     q_ext;
  logic signed [T_W-1:0]     tgt_full;
  logic                      tgt_ovf;
  logic signed [POS_W-1:0]   tgt_sat;
  logic signed [FORCE_W-1:0] avg_w;

  assign p_neg    = gain_q[GAIN_W-1] ^ sum_neg_q;
  assign base_ext = T_W'(base_pos_q[base_idx_q]);
  assign q_ext    = T_W'(div_b_q);
  assign tgt_full = p_neg ? (base_ext - q_ext) : (base_ext + q_ext);
  assign tgt_ovf  = (tgt_full[T_W-1:POS_W-1] != '0) && (tgt_full[T_W-1:POS_W-1] != '1);
  assign avg_w    = sum_neg_q ? FORCE_W'(~div_a_q + 1'b1) : FORCE_W'(div_a_q);

  always_comb begin
    if (!tgt_ovf) begin
      tgt_sat = tgt_full[POS_W-1:0];
    end else if (tgt_full[T_W-1]) begin
      tgt_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      tgt_sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // Output register
  logic                      out_valid_q;
  logic [CH_IN_W-1:0]        out_channel_q;
  logic signed [FORCE_W-1:0] avg_q;
  logic signed [POS_W-1:0]   tgt_q;
  logic                      out_load;

  assign out_load = (state_q == ST_FIN) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_channel_q <= ch_in_q;
      avg_q         <= avg_w;
      tgt_q         <= tgt_sat;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_channel_o     = out_channel_q;
  assign average_force_o   = avg_q;
  assign target_position_o = tgt_q;

  a_accept_starts_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_UPDATE)
    else $error("accepted beat did not start a window update");

  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_update |-> SL_W'(slot_cur_q) < SL_W'(len_w))
    else $error("ring slot beyond window length");

  a_mul_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && state_d == ST_DIV) |-> cnt_q == CNT_W'(SUM_W - 1))
    else $error("multiplier left early");

  a_wlen_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wlen_wr |=> wrapped_q == '0)
    else $error("window length write did not empty the windows");

  a_fin_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && state_d == ST_IDLE) |=> out_valid_o)
    else $error("finished item produced no result beat");

endmodule

[tb/windowed_force_admittance_tb.sv]
`timescale 1ns / 1ps

module windowed_force_admittance_tb;
  import wfa_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TOTAL_BEATS = 1400;
  localparam int LONG_HOLD   = 400;
  localparam int PLAN_ROWS   = 31;
  localparam int WANT_DEPTH  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam longint POS_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint POS_MIN = -64'sh0000_0000_8000_0000;

  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_e;

  typedef struct packed {
    logic [CH_IN_W-1:0]        ch;
    logic signed [FORCE_W-1:0] avg;
    logic signed [POS_W-1:0]   tgt;
  } force_result_t;

  typedef struct packed {
    row_kind_e                 kind;
    logic [CFG_IDX_W-1:0]      idx;
    logic [POS_W-1:0]          value;
    logic [CH_IN_W-1:0]        ch;
    logic signed [FORCE_W-1:0] f;
    logic                      pinned;
    logic signed [FORCE_W-1:0] avg;
    logic signed [POS_W-1:0]   tgt;
  } plan_row_t;

  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd0, 16'sd0, 1'b1, 16'sd0, 32'sd0},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd3, 16'sd32767, 1'b1, 16'sd2047, 32'sd0},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd1, -16'sd32768, 1'b1, -16'sd2048, 32'sd0},
    '{ROW_WRITE, CFG_WINDOW_LENGTH, 32'hFFFF_FF81, 2'd0, 16'sd0, 1'b0, 16'sd0, 32'sd0},
    '{ROW_WRITE, CFG_GAIN, 32'hAA7F_FFFF, 2'd0, 16'sd0, 1'b0, 16'sd0, 32'sd0},
    '{ROW_WRITE, CFG_BASE_POS_0, 32'h7FFF_FFFF, 2'd0, 16'sd0, 1'b0, 16'sd0, 32'sd0},
    '{ROW_WRITE, CFG_BASE_POS_1, 32'h8000_0000, 2'd0, 16'sd0, 1'b0, 16'sd0, 32'sd0},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd0, 16'sd32767, 1'b1, 16'sd32767, 32'sh7FFF_FFFF},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd1, -16'sd32768, 1'b1, -16'sd32768,
      32'sh8000_0000},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd2, -16'sd32768, 1'b1, -16'sd32768,
      -32'sd262143},
    '{ROW_WRITE, CFG_GAIN, 32'h0080_0000, 2'd0, 16'sd0, 1'b0, 16'sd0, 32'sd0},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd3, 16'sd32767, 1'b1, 16'sd32767, -32'sd262136},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd0, -16'sd32768, 1'b1, -16'sd32768,
      32'sh7FFF_FFFF},
    '{ROW_WRITE, CFG_WINDOW_LENGTH, 32'h0000_0000, 2'd0, 16'sd0, 1'b0, 16'sd0, 32'sd0},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd2, -16'sd32768, 1'b1, -16'sd32768,
      32'sd262144},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd2, 16'sd100, 1'b1, 16'sd100, -32'sd800},
    '{ROW_WRITE, CFG_WINDOW_LENGTH, 32'h5555_557F, 2'd0, 16'sd0, 1'b0, 16'sd0, 32'sd0},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd0, 16'sd1000, 1'b0, 16'sd0, 32'sd0},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd0, -16'sd3, 1'b0, 16'sd0, 32'sd0},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd1, 16'sd5, 1'b0, 16'sd0, 32'sd0},
    '{ROW_WRITE, CFG_SPARE_6, 32'hFFFF_FFFF, 2'd0, 16'sd0, 1'b0, 16'sd0, 32'sd0},
    '{ROW_WRITE, CFG_SPARE_7, 32'h1234_5678, 2'd0, 16'sd0, 1'b0, 16'sd0, 32'sd0},
    '{ROW_WRITE, CFG_WINDOW_LENGTH, 32'h0000_0002, 2'd0, 16'sd0, 1'b0, 16'sd0, 32'sd0},
    '{ROW_WRITE, CFG_GAIN, 32'h0000_1000, 2'd0, 16'sd0, 1'b0, 16'sd0, 32'sd0},
    '{ROW_WRITE, CFG_BASE_POS_2, 32'hFFFF_FF00, 2'd0, 16'sd0, 1'b0, 16'sd0, 32'sd0},
    '{ROW_WRITE, CFG_BASE_POS_3, 32'h0000_0100, 2'd0, 16'sd0, 1'b0, 16'sd0, 32'sd0},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd2, 16'sd4096, 1'b0, 16'sd0, 32'sd0},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd2, 16'sd4096, 1'b0, 16'sd0, 32'sd0},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd2, -16'sd4096, 1'b0, 16'sd0, 32'sd0},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd3, 16'sd7, 1'b0, 16'sd0, 32'sd0},
    '{ROW_BEAT,  CFG_WINDOW_LENGTH, 32'h0, 2'd3, -16'sd7, 1'b0, 16'sd0, 32'sd0}
  };

  logic                      clk_i;
  logic                      rst_ni         = 1'b0;
  logic                      cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i      = '0;
  logic [POS_W-1:0]          cfg_data_i     = '0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_stall_o;
  logic [CH_IN_W-1:0]        channel_i      = '0;
  logic signed [FORCE_W-1:0] force_sample_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i    = 1'b0;
  logic [CH_IN_W-1:0]        out_channel_o;
  logic signed [FORCE_W-1:0] average_force_o;
  logic signed [POS_W-1:0]   target_position_o;

  windowed_force_admittance u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .channel_i         (channel_i),
    .force_sample_i    (force_sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_channel_o     (out_channel_o),
    .average_force_o   (average_force_o),
    .target_position_o (target_position_o)
  );

  shortint        ring_mem [CHANNELS_DEF][MAX_WINDOW_DEF];
  int             ring_sum [CHANNELS_DEF];
  int             ring_head [CHANNELS_DEF];
  logic [WLEN_W-1:0] wlen_q;
  int             gain_q;
  int             base_q [NUM_BASE];

  force_result_t  want_buf [WANT_DEPTH];
  int             want_wr         = 0;
  int             want_rd         = 0;
  int             beats_sent;
  int             writes_done;
  int             results_checked = 0;
  int             mismatches      = 0;
  int             quiet_cycles    = 0;
  bit             idle_in;
  bit             idle_out;
  int             long_hold_asks  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_windows();
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      ring_sum[c]  = 0;
      ring_head[c] = 0;
      for (int s = 0; s < MAX_WINDOW_DEF; s++) ring_mem[c][s] = 0;
    end
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [POS_W-1:0] data);
    case (idx)
      CFG_WINDOW_LENGTH: begin
        wlen_q = data[WLEN_W-1:0];
        clear_windows();
      end
      CFG_GAIN: gain_q = {{(32-GAIN_W){data[GAIN_W-1]}}, data[GAIN_W-1:0]};
      CFG_BASE_POS_0, CFG_BASE_POS_1, CFG_BASE_POS_2, CFG_BASE_POS_3: begin
        base_q[idx - CFG_BASE_POS_0] = data;
      end
      default: ;
    endcase
  endfunction

  function automatic force_result_t predict_admittance(input logic [CH_IN_W-1:0] ch,
                                                       input logic signed [FORCE_W-1:0] f);
    force_result_t res;
    int            len;
    int            slot;
    longint        total;
    longint        mean;
    longint        offset;
    longint        goal;
    if (wlen_q == 0) len = 1;
    else if (wlen_q > MAX_WINDOW_DEF) len = MAX_WINDOW_DEF;
    else len = int'(wlen_q);
    slot = ring_head[ch];
    if (slot >= len) slot = 0;
    total = longint'(ring_sum[ch]) - longint'(ring_mem[ch][slot]) + longint'(f);
    ring_mem[ch][slot] = f;
    ring_sum[ch] = int'(total);
    slot++;
    if (slot >= len) slot = 0;
    ring_head[ch] = slot;
    mean   = total / longint'(len);
    offset = (longint'(gain_q) * total) / (longint'(len) <<< FRAC_SHIFT);
    goal   = longint'(base_q[ch]) + offset;
    if (goal > POS_MAX) goal = POS_MAX;
    if (goal < POS_MIN) goal = POS_MIN;
    res.ch  = ch;
    res.avg = mean[FORCE_W-1:0];
    res.tgt = goal[POS_W-1:0];
    return res;
  endfunction

  function automatic logic signed [FORCE_W-1:0] draw_force();
    logic [31:0]               word;
    logic signed [FORCE_W-1:0] f;
    word = $urandom();
    case ($urandom_range(0, 5))
      0:       f = word[0] ? 16'sh7FFF : 16'sh8000;
      1:       f = $signed(word[7:0]);
      default: f = word[FORCE_W-1:0];
    endcase
    return f;
  endfunction

  function automatic int want_count();
    return want_wr - want_rd;
  endfunction

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (want_count() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] data);
    wait_for_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_register(idx, data);
    writes_done++;
  endtask

  task automatic send_force(input logic [CH_IN_W-1:0] ch, input logic signed [FORCE_W-1:0] f,
                            input logic pinned, input logic signed [FORCE_W-1:0] pin_avg,
                            input logic signed [POS_W-1:0] pin_tgt);
    force_result_t res;
    int unsigned   gap;
    gap = idle_in ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    channel_i      <= ch;
    force_sample_i <= f;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = predict_admittance(ch, f);
    if (pinned) begin
      res.avg = pin_avg;
      res.tgt = pin_tgt;
    end
    want_buf[want_wr % WANT_DEPTH] = res;
    want_wr++;
    beats_sent++;
  endtask

  task automatic retune_registers();
    logic [31:0] word;
    if ($urandom_range(0, 2) == 0) begin
      word = $urandom();
      case ($urandom_range(0, 7))
        0:       word[WLEN_W-1:0] = 7'd0;
        1:       word[WLEN_W-1:0] = 7'd1;
        2:       word[WLEN_W-1:0] = 7'd64;
        3:       word[WLEN_W-1:0] = 7'($urandom_range(65, 127));
        4:       word[WLEN_W-1:0] = 7'($urandom_range(17, 63));
        default: word[WLEN_W-1:0] = 7'($urandom_range(1, 16));
      endcase
      write_register(CFG_WINDOW_LENGTH, word);
    end
    if ($urandom_range(0, 1) == 1) begin
      word = $urandom();
      case ($urandom_range(0, 4))
        0:       word[GAIN_W-1:0] = 24'h7F_FFFF;
        1:       word[GAIN_W-1:0] = 24'h80_0000;
        2:       word[GAIN_W-1:0] = 24'($signed(word[12:0]));
        default: ;
      endcase
      write_register(CFG_GAIN, word);
    end
    for (int b = 0; b < NUM_BASE; b++) begin
      if ($urandom_range(0, 1) == 1) begin
        word = $urandom();
        case ($urandom_range(0, 3))
          0:       word = {~word[0], {31{word[0]}}};
          1:       word = 32'($signed(word[15:0]));
          default: ;
        endcase
        write_register(CFG_IDX_W'(CFG_BASE_POS_0 + b), word);
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      word = $urandom();
      write_register(word[0] ? CFG_SPARE_6 : CFG_SPARE_7, $urandom());
    end
  endtask

  initial begin : result_sink
    int unsigned hold;
    int          served;
    served = 0;
    forever begin
      if (long_hold_asks != served) begin
        hold   = LONG_HOLD;
        served = long_hold_asks;
      end else begin
        hold = idle_out ? $urandom_range(0, 12) : 0;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    force_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (want_count() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, channel %0d", $time, out_channel_o);
      end else begin
        want = want_buf[want_rd % WANT_DEPTH];
        want_rd++;
        if (out_channel_o !== want.ch) begin
          mismatches++;
          $display("%0t: out_channel expected %0d got %0d", $time, want.ch, out_channel_o);
        end
        if (average_force_o !== want.avg) begin
          mismatches++;
          $display("%0t: average_force expected %0d got %0d", $time, want.avg,
                   average_force_o);
        end
        if (target_position_o !== want.tgt) begin
          mismatches++;
          $display("%0t: target_position expected %0d got %0d", $time, want.tgt,
                   target_position_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding", $time, QUIET_LIMIT,
               want_count());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int            phase;
    int            n;
    logic [1:0]    focus;
    wlen_q = WLEN_RESET;
    gain_q = GAIN_RESET;
    for (int b = 0; b < NUM_BASE; b++) base_q[b] = 0;
    clear_windows();
    beats_sent      = 0;
    writes_done     = 0;
    idle_in         = 1'b1;
    idle_out        = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (DIRECTED_PLAN[i].kind == ROW_WRITE) begin
        write_register(DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].value);
      end else begin
        send_force(DIRECTED_PLAN[i].ch, DIRECTED_PLAN[i].f, DIRECTED_PLAN[i].pinned,
                   DIRECTED_PLAN[i].avg, DIRECTED_PLAN[i].tgt);
      end
    end

    phase = 0;
    while (beats_sent < TOTAL_BEATS) begin
      retune_registers();
      {idle_out, idle_in} = 2'($urandom_range(0, 3));
      focus = 2'($urandom_range(0, 3));
      if (phase == 2) begin
        // back the block up behind a stalled receiver, then wait for it to empty
        idle_in = 1'b0;
        long_hold_asks++;
        repeat (8) send_force(2'($urandom_range(0, 3)), draw_force(), 1'b0, '0, '0);
        wait_for_results();
      end
      n = $urandom_range(30, 120);
      if (n > TOTAL_BEATS - beats_sent) n = TOTAL_BEATS - beats_sent;
      repeat (n) begin
        send_force($urandom_range(0, 1) ? focus : 2'($urandom_range(0, 3)), draw_force(),
                   1'b0, '0, '0);
      end
      phase++;
    end

    wait_for_results();
    repeat (64) @(posedge clk_i);
    $display("Run covered %0d force beats in %0d phases with %0d register writes,",
             beats_sent, phase, writes_done);
    $display("window lengths 0 to 127 and saturated targets; %0d result beats compared.",
             results_checked);
    if (mismatches == 0 && want_count() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
